>>> rtl/magnetometer_frame_calibrate_defines.svh
// Assertion macros used by magnetometer_frame_calibrate.sv.
`ifndef MAGNETOMETER_FRAME_CALIBRATE_DEFINES_SVH
`define MAGNETOMETER_FRAME_CALIBRATE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define MFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define MFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mfc_pkg.sv
package mfc_pkg;

    // Field and datapath widths
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int DIFF_W      = RAW_W + 1;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = COEF_W + DIFF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int CAL_W       = 28;
    localparam int ROW_W       = 3 * COEF_W;
    localparam int AXES        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = ROW_W;
    localparam int POS_W       = 3;
    localparam int HELD_BYTES  = 5;
    localparam int OUT_DATA_W  = 3 * RAW_W + 3 * CAL_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    // Fixed-point format
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int OUT_FRAC_BITS      = 8;

    // Position of the last byte of a frame
    localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(5);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z  = CFG_IDX_W'(5);

    // Matrix reset: one 1.0 coefficient on the diagonal
    localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(48'h0000_0000_4000);
    localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(48'h0000_4000_0000);
    localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(48'h4000_0000_0000);

    typedef logic signed [RAW_W-1:0]  t_raw;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [CAL_W-1:0]  t_cal;

endpackage

>>> rtl/magnetometer_frame_calibrate.sv
// Channel   | Dir | Ports                          | Contents
// ----------+-----+--------------------------------+-------------------------------------
// s (bytes) | in  | i_s_tvalid/o_s_tready          | tdata: frame_byte; tuser: frame_start
// m (frame) | out | o_m_tvalid/i_m_tready          | tdata: raw x,y,z, cal x,y,z
// cfg       | in  | i_cfg_we/i_cfg_index/i_cfg_data| bias x,y,z, matrix rows x,y,z
//
// One byte item is taken per cycle while o_s_tready is high. After its sixth byte a frame
// result passes the frame register, the nine-multiplier product register, then the
// sum/shift/saturate output register.
// Synchronous active-low reset clears the byte count, the pipe valids and the bias
// registers, and sets the matrix rows to their reset values. A stalled output holds the
// pipe; input keeps flowing while the first pipe stage has room.
`include "magnetometer_frame_calibrate_defines.svh"

module magnetometer_frame_calibrate
    import mfc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // byte input
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [BYTE_W-1:0]      i_s_tdata,   // [7:0] frame_byte
    input  logic                   i_s_tuser,   // [0] frame_start
    // frame result
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // raw_x, raw_y, raw_z, cal_x, cal_y,
                                                // cal_z, zero pad
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SHIFT = COEF_FRAC_BITS - OUT_FRAC_BITS;
    localparam t_sum CAL_MAX_S = {{(SUM_W-CAL_W+1){1'b0}}, {(CAL_W-1){1'b1}}};
    localparam t_sum CAL_MIN_S = {{(SUM_W-CAL_W+1){1'b1}}, {(CAL_W-1){1'b0}}};

    // configuration registers
    t_raw             r_bias [AXES];
    logic [ROW_W-1:0] r_row  [AXES];

    // frame assembly
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  pos_eff;
    logic [BYTE_W-1:0] r_held [HELD_BYTES];

    // pipe stages
    logic  r_a_valid, r_b_valid, r_o_valid;
    t_raw  r_a_raw [AXES];
    t_raw  r_b_raw [AXES];
    t_prod r_prod  [AXES][AXES];
    t_raw  r_o_raw [AXES];
    t_cal  r_o_cal [AXES];

    logic s_fire, frame_end;
    logic en_a, en_b, en_o;
    logic signed [DIFF_W-1:0] diff [AXES];
    t_sum sum     [AXES];
    t_sum shifted [AXES];
    t_cal n_cal   [AXES];

    // stall chain: each stage moves when the next has room
    assign en_o       = !r_o_valid || i_m_tready;
    assign en_b       = !r_b_valid || en_o;
    assign en_a       = !r_a_valid || en_b;
    assign o_s_tready = en_a;
    assign s_fire     = i_s_tvalid && o_s_tready;

    // frame start forces position zero
    assign pos_eff   = i_s_tuser ? '0 : r_pos;
    assign frame_end = (pos_eff == FRAME_LAST);
    assign n_pos     = frame_end ? '0 : pos_eff + POS_W'(1);

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias[0] <= '0;
            r_bias[1] <= '0;
            r_bias[2] <= '0;
            r_row[0]  <= ROW_X_RESET;
            r_row[1]  <= ROW_Y_RESET;
            r_row[2]  <= ROW_Z_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIAS_X: r_bias[0] <= i_cfg_data[RAW_W-1:0];
                CFG_BIAS_Y: r_bias[1] <= i_cfg_data[RAW_W-1:0];
                CFG_BIAS_Z: r_bias[2] <= i_cfg_data[RAW_W-1:0];
                CFG_ROW_X:  r_row[0]  <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Y:  r_row[1]  <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Z:  r_row[2]  <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // byte count and pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_pos <= n_pos;
            end
            if (en_a) begin
                r_a_valid <= s_fire && frame_end;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    // held bytes and assembled frame
    always_ff @(posedge i_clk) begin
        if (s_fire && !frame_end) begin
            r_held[pos_eff] <= i_s_tdata;
        end
        if (en_a && s_fire && frame_end) begin
            r_a_raw[0] <= {r_held[0], r_held[1]};
            r_a_raw[1] <= {r_held[4], i_s_tdata};
            r_a_raw[2] <= {r_held[2], r_held[3]};
        end
    end

    // bias removal, 17-bit differences
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            diff[a] = DIFF_W'(r_a_raw[a]) - DIFF_W'(r_bias[a]);
        end
    end

    // nine coefficient products
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            for (int r = 0; r < AXES; r++) begin
                r_b_raw[r] <= r_a_raw[r];
                for (int c = 0; c < AXES; c++) begin
                    r_prod[r][c] <= PROD_W'($signed(r_row[r][c*COEF_W +: COEF_W]))
                                  * PROD_W'(diff[c]);
                end
            end
        end
    end

    // row sums, floor shift to 8 fraction bits, saturate
    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            sum[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]) + SUM_W'(r_prod[r][2]);
            shifted[r] = sum[r] >>> SHIFT;
            if (shifted[r] > CAL_MAX_S) begin
                n_cal[r] = CAL_MAX_S[CAL_W-1:0];
            end else if (shifted[r] < CAL_MIN_S) begin
                n_cal[r] = CAL_MIN_S[CAL_W-1:0];
            end else begin
                n_cal[r] = shifted[r][CAL_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (en_o) begin
            for (int r = 0; r < AXES; r++) begin
                r_o_raw[r] <= r_b_raw[r];
                r_o_cal[r] <= n_cal[r];
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-OUT_DATA_W){1'b0}},
                         r_o_cal[2], r_o_cal[1], r_o_cal[0],
                         r_o_raw[2], r_o_raw[1], r_o_raw[0]};

    // byte count stays inside a frame
    `MFC_ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= FRAME_LAST)
    // a sixth byte always lands in the frame register
    `MFC_ASSERT_NEXT(a_frame_loaded, i_clk, i_rst_n, s_fire && frame_end, r_a_valid)
    // a non-final byte advances the count by one
    `MFC_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, s_fire && !frame_end,
                     r_pos == $past(pos_eff) + POS_W'(1))
    // a product stage that cannot move keeps its frame
    `MFC_ASSERT_NEXT(a_prod_hold, i_clk, i_rst_n, r_b_valid && !en_b, r_b_valid)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mfc_pkg::*;

    localparam int COEF_FRAC     = COEF_FRAC_BITS_DEF;
    localparam int PIPE_LATENCY  = 3;
    localparam int STALL_LIMIT   = 2000;
    localparam longint CAL_HI    = (64'sd1 <<< (CAL_W - 1)) - 1;
    localparam longint CAL_LO    = -(64'sd1 <<< (CAL_W - 1));

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

    typedef struct {
        t_raw raw_x;
        t_raw raw_y;
        t_raw raw_z;
        t_cal cal_x;
        t_cal cal_y;
        t_cal cal_z;
        logic [OUT_TDATA_W-OUT_DATA_W-1:0] pad;
    } t_frame_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata = '0;    // [7:0] frame_byte
    logic                   i_s_tuser = 1'b0;  // [0] frame_start
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z,
                                               // [75:48] cal_x, [103:76] cal_y,
                                               // [131:104] cal_z, zero pad
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Predictor copy of the block's state and registers
    t_raw               offset_x = '0;
    t_raw               offset_y = '0;
    t_raw               offset_z = '0;
    logic [ROW_W-1:0]   coef_row_x = ROW_X_RESET;
    logic [ROW_W-1:0]   coef_row_y = ROW_Y_RESET;
    logic [ROW_W-1:0]   coef_row_z = ROW_Z_RESET;
    logic [POS_W-1:0]   frame_pos = '0;
    logic [BYTE_W-1:0]  frame_bytes [HELD_BYTES];

    t_frame_result expected_frames [$];
    int  error_count = 0;
    int  quiet_cycles = 0;
    int  sink_stall_left = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;

    magnetometer_frame_calibrate #(
        .COEF_FRAC_BITS(COEF_FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One calibrated axis: exact dot product, floor shift to 8 fraction bits, clamp
    function automatic t_cal calibrate_axis(logic [ROW_W-1:0] row, longint dx, longint dy,
                                            longint dz);
        longint acc;
        acc = longint'($signed(row[COEF_W-1:0])) * dx
            + longint'($signed(row[2*COEF_W-1:COEF_W])) * dy
            + longint'($signed(row[3*COEF_W-1:2*COEF_W])) * dz;
        acc = acc >>> (COEF_FRAC - OUT_FRAC_BITS);
        if (acc > CAL_HI) begin
            acc = CAL_HI;
        end
        if (acc < CAL_LO) begin
            acc = CAL_LO;
        end
        return t_cal'(acc);
    endfunction

    // Byte assembly; the sixth byte queues a frame result
    function automatic void track_byte(logic [BYTE_W-1:0] b, logic start);
        t_frame_result r;
        longint dx, dy, dz;
        if (start) begin
            frame_pos = '0;
        end
        if (frame_pos < FRAME_LAST) begin
            frame_bytes[frame_pos] = b;
            frame_pos = frame_pos + 1'b1;
        end else begin
            frame_pos = '0;
            r.raw_x = {frame_bytes[0], frame_bytes[1]};
            r.raw_z = {frame_bytes[2], frame_bytes[3]};
            r.raw_y = {frame_bytes[4], b};
            dx = longint'(r.raw_x) - longint'(offset_x);
            dy = longint'(r.raw_y) - longint'(offset_y);
            dz = longint'(r.raw_z) - longint'(offset_z);
            r.cal_x = calibrate_axis(coef_row_x, dx, dy, dz);
            r.cal_y = calibrate_axis(coef_row_y, dx, dy, dz);
            r.cal_z = calibrate_axis(coef_row_z, dx, dy, dz);
            r.pad = '0;
            expected_frames.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Frame result checker
    always @(posedge i_clk) begin
        t_frame_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.raw_x = o_m_tdata[RAW_W-1:0];
            got.raw_y = o_m_tdata[2*RAW_W-1:RAW_W];
            got.raw_z = o_m_tdata[3*RAW_W-1:2*RAW_W];
            got.cal_x = o_m_tdata[3*RAW_W+CAL_W-1:3*RAW_W];
            got.cal_y = o_m_tdata[3*RAW_W+2*CAL_W-1:3*RAW_W+CAL_W];
            got.cal_z = o_m_tdata[3*RAW_W+3*CAL_W-1:3*RAW_W+2*CAL_W];
            got.pad   = o_m_tdata[OUT_TDATA_W-1:OUT_DATA_W];
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected frame, raw_x", got.raw_x, 0);
            end else begin
                want = expected_frames.pop_front();
                if (got.raw_x !== want.raw_x) report_mismatch("raw_x", got.raw_x, want.raw_x);
                if (got.raw_y !== want.raw_y) report_mismatch("raw_y", got.raw_y, want.raw_y);
                if (got.raw_z !== want.raw_z) report_mismatch("raw_z", got.raw_z, want.raw_z);
                if (got.cal_x !== want.cal_x) report_mismatch("cal_x", got.cal_x, want.cal_x);
                if (got.cal_y !== want.cal_y) report_mismatch("cal_y", got.cal_y, want.cal_y);
                if (got.cal_z !== want.cal_z) report_mismatch("cal_z", got.cal_z, want.cal_z);
                if (got.pad !== want.pad) report_mismatch("pad", got.pad, want.pad);
            end
        end
    end

    // Result sink: ready with random stall bursts
    always @(negedge i_clk) begin
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            i_m_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_stall_left = $urandom_range(1, 18) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one byte item; called and returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        do @(posedge i_clk); while (!o_s_tready);
        track_byte(b, start);
        @(negedge i_clk);
    endtask

    task automatic send_axes(input t_raw x, input t_raw y, input t_raw z);
        send_byte(x[15:8], 1'b1);
        send_byte(x[7:0], 1'b0);
        send_byte(z[15:8], 1'b0);
        send_byte(z[7:0], 1'b0);
        send_byte(y[15:8], 1'b0);
        send_byte(y[7:0], 1'b0);
    endtask

    // Stop sending and wait for every queued result to drain
    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        i_cfg_we   <= 1'b0;
        do @(negedge i_clk); while (expected_frames.size() != 0);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    // Raise a write for the next rising edge; the caller lowers the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_BIAS_X: offset_x = data[RAW_W-1:0];
            CFG_BIAS_Y: offset_y = data[RAW_W-1:0];
            CFG_BIAS_Z: offset_z = data[RAW_W-1:0];
            CFG_ROW_X:  coef_row_x = data;
            CFG_ROW_Y:  coef_row_y = data;
            CFG_ROW_Z:  coef_row_z = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Bias writes carry random junk above bit 15, which the block drops
    task automatic apply_config(input t_raw bx, input t_raw by, input t_raw bz,
                                input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                                input logic [ROW_W-1:0] rz);
        quiesce();
        write_reg(CFG_BIAS_X, {$urandom, bx});
        write_reg(CFG_BIAS_Y, {$urandom, by});
        write_reg(CFG_BIAS_Z, {$urandom, bz});
        write_reg(CFG_ROW_X, rx);
        write_reg(CFG_ROW_Y, ry);
        write_reg(CFG_ROW_Z, rz);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h4000;
            4: return 16'hc000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic t_raw rand_bias();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return t_raw'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Mostly clean frames; some without a start flag, cut short, stray or resynced
    task automatic send_random_frames(input int n_items, input bit vary_idle);
        int  sent;
        int  kind;
        int  len;
        logic flag;
        sent = 0;
        while (sent < n_items) begin
            if (vary_idle && $urandom_range(0, 15) == 0) begin
                src_idle_on  = 1'($urandom_range(0, 1));
                sink_idle_on = 1'($urandom_range(0, 1));
            end
            kind = $urandom_range(0, 19);
            if (kind == 16 || kind == 17) begin
                len = $urandom_range(1, 5);
            end else if (kind == 18) begin
                len = 1;
            end else begin
                len = 6;
            end
            for (int k = 0; k < len; k++) begin
                if (kind == 14 || kind == 15) begin
                    flag = 1'b0;
                end else if (kind == 18) begin
                    flag = 1'($urandom_range(0, 1));
                end else if (kind == 19) begin
                    flag = (k == 0) || ($urandom_range(0, 3) == 0);
                end else begin
                    flag = (k == 0);
                end
                send_byte(rand_byte(), flag);
            end
            sent += len;
        end
    endtask

    task automatic apply_random_config();
        apply_config(rand_bias(), rand_bias(), rand_bias(),
                     {rand_coef(), rand_coef(), rand_coef()},
                     {rand_coef(), rand_coef(), rand_coef()},
                     {rand_coef(), rand_coef(), rand_coef()});
    endtask

    // Reset matrix is the identity: cal = raw << 8. First frame relies on the reset count.
    task automatic test_reset_identity();
        send_byte(8'h7f, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    // A start flag mid-frame throws away the partial frame
    task automatic test_resync();
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_axes(16'sh1234, -16'sd2, 16'sh7f00);
    endtask

    // Largest differences against the most negative coefficients
    task automatic test_extreme_negative();
        apply_config(16'sh7fff, 16'sh8000, 16'sh7fff,
                     48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
        send_axes(16'sh8000, 16'sh7fff, 16'sh8000);
    endtask

    // Writes to unused indexes change nothing; then largest positive, most negative and mixed rows
    task automatic test_spare_and_positive();
        quiesce();
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, CFG_DATA_W'({$urandom, $urandom}));
        apply_config(16'sh8000, 16'sh7fff, 16'sh8000,
                     48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h0001_7fff_8000);
        send_axes(16'sh7fff, 16'sh8000, 16'sh7fff);
    endtask

    task automatic test_random_traffic();
        apply_config(rand_bias(), rand_bias(), rand_bias(),
                     ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase != 0) begin
                apply_random_config();
            end
            if (phase == 3) begin
                send_random_frames(105, 1'b1);
                quiesce();
                send_random_frames(105, 1'b1);
            end else begin
                send_random_frames(210, 1'b1);
            end
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate_tail();
        apply_random_config();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_frames(180, 1'b0);
        quiesce();
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_identity();
        test_resync();
        test_extreme_negative();
        test_spare_and_positive();
        test_random_traffic();
        test_full_rate_tail();
        repeat (4 * PIPE_LATENCY) @(negedge i_clk);
        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mfc_pkg.sv
rtl/magnetometer_frame_calibrate.sv
verif/testbench.sv
